### hw/rtl/assert_macros.svh
// assertion macros used by the parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define FCP_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define FCP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### hw/rtl/fcp_pkg.sv
// types, codes and keyword table of the ftp command line parser
package fcp_pkg;

    localparam logic [5:0] ID_NONE = 6'd48;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNREC = 3'd1;
    localparam logic [2:0] ST_NOARG = 3'd2;
    localparam logic [2:0] ST_LOGIN = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    localparam logic [9:0] RC_NONE  = 10'd0;
    localparam logic [9:0] RC_UNREC = 10'd500;
    localparam logic [9:0] RC_NOARG = 10'd501;
    localparam logic [9:0] RC_LOGIN = 10'd530;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_LOW_A  = 8'd97;
    localparam logic [7:0] CH_LOW_Z  = 8'd122;
    localparam logic [7:0] CH_CASE   = 8'd32;
    localparam logic [7:0] TN_CMD_LO = 8'd240;
    localparam logic [7:0] TN_IAC    = 8'd255;

    localparam int KW_COUNT = 53;

    localparam logic [2:0] KLEN_WORD = 3'd4;
    localparam logic [2:0] KLEN_LONG = 3'd5;

    localparam logic KIND_ARG     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  id;
        logic        needs_arg;
        logic        before_logon;
    } t_kw_entry;

    typedef struct packed {
        logic [5:0] command_id;
        logic [2:0] status;
        logic [9:0] reply_code;
    } t_verdict;

    localparam t_kw_entry KW_TABLE [KW_COUNT] = '{
        '{"USER", 6'd0, 1'b1, 1'b1},  '{"PASS", 6'd1, 1'b0, 1'b1},
        '{"QUIT", 6'd2, 1'b0, 1'b1},  '{{8'h00, "CWD"}, 6'd3, 1'b0, 1'b0},
        '{{8'h00, "PWD"}, 6'd4, 1'b0, 1'b0}, '{"PORT", 6'd5, 1'b1, 1'b0},
        '{"PASV", 6'd6, 1'b0, 1'b0},  '{"TYPE", 6'd7, 1'b1, 1'b0},
        '{"LIST", 6'd8, 1'b0, 1'b0},  '{"REST", 6'd9, 1'b1, 1'b0},
        '{"CDUP", 6'd10, 1'b0, 1'b0}, '{"RETR", 6'd11, 1'b1, 1'b0},
        '{"STOR", 6'd12, 1'b1, 1'b0}, '{"STOU", 6'd13, 1'b1, 1'b0},
        '{"SIZE", 6'd14, 1'b1, 1'b0}, '{"DELE", 6'd15, 1'b1, 1'b0},
        '{{8'h00, "RMD"}, 6'd16, 1'b1, 1'b0}, '{{8'h00, "MKD"}, 6'd17, 1'b1, 1'b0},
        '{"RNFR", 6'd18, 1'b1, 1'b0}, '{"RNTO", 6'd19, 1'b1, 1'b0},
        '{"ABOR", 6'd20, 1'b0, 1'b0}, '{"SYST", 6'd21, 1'b0, 1'b1},
        '{"NOOP", 6'd22, 1'b0, 1'b0}, '{"APPE", 6'd23, 1'b1, 1'b0},
        '{"NLST", 6'd24, 1'b0, 1'b0}, '{"MDTM", 6'd25, 1'b1, 1'b0},
        '{"XPWD", 6'd4, 1'b0, 1'b0},  '{"XCUP", 6'd10, 1'b0, 1'b0},
        '{"XMKD", 6'd17, 1'b1, 1'b0}, '{"XRMD", 6'd16, 1'b1, 1'b0},
        '{"XCWD", 6'd3, 1'b1, 1'b0},  '{{8'h00, "NOP"}, 6'd26, 1'b0, 1'b0},
        '{"EPSV", 6'd27, 1'b0, 1'b0}, '{"EPRT", 6'd28, 1'b1, 1'b0},
        '{"AUTH", 6'd29, 1'b1, 1'b1}, '{"ADAT", 6'd30, 1'b1, 1'b1},
        '{"PBSZ", 6'd31, 1'b1, 1'b1}, '{"PROT", 6'd32, 1'b1, 1'b1},
        '{"FEAT", 6'd33, 1'b0, 1'b1}, '{"MODE", 6'd34, 1'b1, 1'b0},
        '{"OPTS", 6'd35, 1'b1, 1'b1}, '{"HELP", 6'd36, 1'b0, 1'b1},
        '{"ALLO", 6'd37, 1'b0, 1'b0}, '{"MLST", 6'd38, 1'b0, 1'b0},
        '{"MLSD", 6'd39, 1'b0, 1'b0}, '{"SITE", 6'd40, 1'b1, 1'b1},
        '{"P@SW", 6'd41, 1'b0, 1'b0}, '{"STRU", 6'd42, 1'b1, 1'b0},
        '{"CLNT", 6'd43, 1'b1, 1'b1}, '{"MFMT", 6'd44, 1'b1, 1'b0},
        '{"HASH", 6'd45, 1'b1, 1'b0}, '{"REIN", 6'd46, 1'b0, 1'b0},
        '{"STAT", 6'd47, 1'b0, 1'b0}
    };

endpackage

### hw/rtl/fcp_kw_lookup.sv
// keyword match and end-of-line verdict
module fcp_kw_lookup (
    input  logic [31:0]        i_keyword,
    input  logic [2:0]         i_keyword_len,
    input  logic               i_arg_present,
    input  logic               i_logged_on,
    output fcp_pkg::t_verdict  o_verdict
);

    logic [fcp_pkg::KW_COUNT-1:0] hit;
    fcp_pkg::t_kw_entry           sel;
    logic                         found;

    always_comb begin
        for (int i = 0; i < fcp_pkg::KW_COUNT; i++) begin
            hit[i] = (fcp_pkg::KW_TABLE[i].word == i_keyword);
        end
    end

    // first matching entry wins
    always_comb begin
        sel   = fcp_pkg::KW_TABLE[0];
        found = 1'b0;
        for (int i = fcp_pkg::KW_COUNT - 1; i >= 0; i--) begin
            if (hit[i]) begin
                sel   = fcp_pkg::KW_TABLE[i];
                found = 1'b1;
            end
        end
    end

    always_comb begin
        o_verdict.command_id = fcp_pkg::ID_NONE;
        o_verdict.status     = fcp_pkg::ST_UNREC;
        o_verdict.reply_code = fcp_pkg::RC_UNREC;
        if (i_keyword_len == 3'd0) begin
            o_verdict.status     = fcp_pkg::ST_EMPTY;
            o_verdict.reply_code = fcp_pkg::RC_NONE;
        end else if (i_keyword_len <= fcp_pkg::KLEN_WORD && found) begin
            if (sel.needs_arg && !i_arg_present) begin
                o_verdict.status     = fcp_pkg::ST_NOARG;
                o_verdict.reply_code = fcp_pkg::RC_NOARG;
            end else if (!i_logged_on && !sel.before_logon) begin
                o_verdict.status     = fcp_pkg::ST_LOGIN;
                o_verdict.reply_code = fcp_pkg::RC_LOGIN;
            end else begin
                o_verdict.command_id = sel.id;
                o_verdict.status     = fcp_pkg::ST_OK;
                o_verdict.reply_code = fcp_pkg::RC_NONE;
            end
        end
    end

endmodule

### hw/rtl/ftp_command_line_parser.sv
// ftp control connection command line parser, top level
//
// rx channel: one control-connection byte per beat (i_rx_valid / o_rx_ready).
// res channel: one result per beat (o_res_valid / i_res_ready). kind 0 carries an
// argument byte, kind 1 the end-of-line verdict with command id, status and reply.
// a byte causes at most one result; the result appears in the output register
// the cycle after its byte is taken.
// throughput is one byte per cycle: the line state and the keyword compare against
// the 53-entry table both sit between the line state registers and the output
// register, and o_rx_ready stays high while the output register is empty or being
// taken in the same cycle.
// when the receiver stalls with a result pending, o_rx_ready drops and the result
// holds until taken; bytes that give no result still need a free output slot.
// i_cfg_we writes the logged-on flag; write it only while the block is idle.
// reset (synchronous, active low) clears the line state, the telnet skip, the
// logged-on flag and the output valid.
module ftp_command_line_parser #(
    parameter int MAX_LINE = 2000
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_logged_on,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_kind,
    output logic [7:0] o_arg_byte,
    output logic [5:0] o_command_id,
    output logic [2:0] o_status,
    output logic [9:0] o_reply_code
);

`include "assert_macros.svh"

    localparam int LEN_W = $clog2(MAX_LINE + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LINE);

    logic             r_logged_on;
    logic             r_telnet_skip, n_telnet_skip;
    logic [LEN_W-1:0] r_line_len, n_line_len;
    logic             r_space_seen, n_space_seen;
    logic [31:0]      r_keyword, n_keyword;
    logic [2:0]       r_keyword_len, n_keyword_len;
    logic             r_arg_present, n_arg_present;

    logic             r_res_valid;
    logic             r_kind;
    logic [7:0]       r_arg_byte;
    logic [5:0]       r_command_id;
    logic [2:0]       r_status;
    logic [9:0]       r_reply_code;

    logic             accept;
    logic             emit_arg, emit_verdict;
    logic [7:0]       upper;
    fcp_pkg::t_verdict verdict;

    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign accept     = i_rx_valid && o_rx_ready;

    assign upper = (i_rx_byte >= fcp_pkg::CH_LOW_A && i_rx_byte <= fcp_pkg::CH_LOW_Z) ?
                   i_rx_byte - fcp_pkg::CH_CASE : i_rx_byte;

    fcp_kw_lookup u_lookup (
        .i_keyword     (r_keyword),
        .i_keyword_len (r_keyword_len),
        .i_arg_present (r_arg_present),
        .i_logged_on   (r_logged_on),
        .o_verdict     (verdict)
    );

    always_comb begin
        logic drop;
        n_telnet_skip = r_telnet_skip;
        n_line_len    = r_line_len;
        n_space_seen  = r_space_seen;
        n_keyword     = r_keyword;
        n_keyword_len = r_keyword_len;
        n_arg_present = r_arg_present;
        emit_arg      = 1'b0;
        emit_verdict  = 1'b0;
        drop          = 1'b0;
        if (accept) begin
            // telnet sequences are only looked for at line start
            if (r_line_len == '0) begin
                if (r_telnet_skip) begin
                    if (i_rx_byte < fcp_pkg::TN_CMD_LO) begin
                        n_telnet_skip = 1'b0;
                    end else begin
                        drop = 1'b1;
                    end
                end else if (i_rx_byte == fcp_pkg::TN_IAC) begin
                    n_telnet_skip = 1'b1;
                    drop          = 1'b1;
                end
            end
            if (!drop) begin
                if (i_rx_byte == fcp_pkg::CH_CR || i_rx_byte == fcp_pkg::CH_LF ||
                    i_rx_byte == fcp_pkg::CH_NUL) begin
                    if (r_line_len != '0) begin
                        emit_verdict  = 1'b1;
                        n_line_len    = '0;
                        n_space_seen  = 1'b0;
                        n_keyword     = '0;
                        n_keyword_len = '0;
                        n_arg_present = 1'b0;
                    end
                end else if (r_line_len < LEN_MAX) begin
                    n_line_len = r_line_len + 1'b1;
                    if (r_space_seen) begin
                        n_arg_present = 1'b1;
                        emit_arg      = 1'b1;
                    end else if (i_rx_byte == fcp_pkg::CH_SPACE) begin
                        n_space_seen = 1'b1;
                    end else if (r_keyword_len < fcp_pkg::KLEN_WORD) begin
                        n_keyword     = {r_keyword[23:0], upper};
                        n_keyword_len = r_keyword_len + 1'b1;
                    end else begin
                        n_keyword_len = fcp_pkg::KLEN_LONG;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_logged_on   <= 1'b0;
            r_telnet_skip <= 1'b0;
            r_line_len    <= '0;
            r_space_seen  <= 1'b0;
            r_keyword     <= '0;
            r_keyword_len <= '0;
            r_arg_present <= 1'b0;
            r_res_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_logged_on <= i_cfg_logged_on;
            end
            r_telnet_skip <= n_telnet_skip;
            r_line_len    <= n_line_len;
            r_space_seen  <= n_space_seen;
            r_keyword     <= n_keyword;
            r_keyword_len <= n_keyword_len;
            r_arg_present <= n_arg_present;
            if (emit_arg || emit_verdict) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (emit_arg) begin
            r_kind       <= fcp_pkg::KIND_ARG;
            r_arg_byte   <= i_rx_byte;
            r_command_id <= fcp_pkg::ID_NONE;
            r_status     <= fcp_pkg::ST_OK;
            r_reply_code <= fcp_pkg::RC_NONE;
        end else if (emit_verdict) begin
            r_kind       <= fcp_pkg::KIND_VERDICT;
            r_arg_byte   <= 8'd0;
            r_command_id <= verdict.command_id;
            r_status     <= verdict.status;
            r_reply_code <= verdict.reply_code;
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_kind       = r_kind;
    assign o_arg_byte   = r_arg_byte;
    assign o_command_id = r_command_id;
    assign o_status     = r_status;
    assign o_reply_code = r_reply_code;

    `FCP_ASSERT_NOW(a_skip_at_line_start, i_clk, i_rst_n, r_telnet_skip, r_line_len == '0)
    `FCP_ASSERT_NOW(a_len_bounded, i_clk, i_rst_n, 1'b1,
                    r_line_len <= LEN_MAX && r_keyword_len <= fcp_pkg::KLEN_LONG)
    `FCP_ASSERT_NOW(a_arg_after_space, i_clk, i_rst_n, r_res_valid && r_kind == fcp_pkg::KIND_ARG,
                    r_space_seen && r_arg_present)
    `FCP_ASSERT_NEXT(a_verdict_clears, i_clk, i_rst_n, emit_verdict,
                     r_line_len == '0 && !r_space_seen && r_keyword_len == '0)

endmodule

### sim/ftp_command_line_parser_test.sv
// self-checking testbench for the ftp command line parser
`timescale 1ns / 1ps

module ftp_command_line_parser_test;

    localparam int LINE_LIMIT  = 2000;
    localparam int LONG_ARG    = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 4;
    localparam int N_CMDS      = 53;

    // command words as the server knows them, aliases share an id
    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  id;
        logic        arg_req;
        logic        open_cmd;
    } t_cmd_row;

    localparam t_cmd_row COMMANDS [N_CMDS] = '{
        '{"USER", 6'd0, 1'b1, 1'b1},  '{"PASS", 6'd1, 1'b0, 1'b1},
        '{"QUIT", 6'd2, 1'b0, 1'b1},  '{"CWD", 6'd3, 1'b0, 1'b0},
        '{"PWD", 6'd4, 1'b0, 1'b0},   '{"PORT", 6'd5, 1'b1, 1'b0},
        '{"PASV", 6'd6, 1'b0, 1'b0},  '{"TYPE", 6'd7, 1'b1, 1'b0},
        '{"LIST", 6'd8, 1'b0, 1'b0},  '{"REST", 6'd9, 1'b1, 1'b0},
        '{"CDUP", 6'd10, 1'b0, 1'b0}, '{"RETR", 6'd11, 1'b1, 1'b0},
        '{"STOR", 6'd12, 1'b1, 1'b0}, '{"STOU", 6'd13, 1'b1, 1'b0},
        '{"SIZE", 6'd14, 1'b1, 1'b0}, '{"DELE", 6'd15, 1'b1, 1'b0},
        '{"RMD", 6'd16, 1'b1, 1'b0},  '{"MKD", 6'd17, 1'b1, 1'b0},
        '{"RNFR", 6'd18, 1'b1, 1'b0}, '{"RNTO", 6'd19, 1'b1, 1'b0},
        '{"ABOR", 6'd20, 1'b0, 1'b0}, '{"SYST", 6'd21, 1'b0, 1'b1},
        '{"NOOP", 6'd22, 1'b0, 1'b0}, '{"APPE", 6'd23, 1'b1, 1'b0},
        '{"NLST", 6'd24, 1'b0, 1'b0}, '{"MDTM", 6'd25, 1'b1, 1'b0},
        '{"XPWD", 6'd4, 1'b0, 1'b0},  '{"XCUP", 6'd10, 1'b0, 1'b0},
        '{"XMKD", 6'd17, 1'b1, 1'b0}, '{"XRMD", 6'd16, 1'b1, 1'b0},
        '{"XCWD", 6'd3, 1'b1, 1'b0},  '{"NOP", 6'd26, 1'b0, 1'b0},
        '{"EPSV", 6'd27, 1'b0, 1'b0}, '{"EPRT", 6'd28, 1'b1, 1'b0},
        '{"AUTH", 6'd29, 1'b1, 1'b1}, '{"ADAT", 6'd30, 1'b1, 1'b1},
        '{"PBSZ", 6'd31, 1'b1, 1'b1}, '{"PROT", 6'd32, 1'b1, 1'b1},
        '{"FEAT", 6'd33, 1'b0, 1'b1}, '{"MODE", 6'd34, 1'b1, 1'b0},
        '{"OPTS", 6'd35, 1'b1, 1'b1}, '{"HELP", 6'd36, 1'b0, 1'b1},
        '{"ALLO", 6'd37, 1'b0, 1'b0}, '{"MLST", 6'd38, 1'b0, 1'b0},
        '{"MLSD", 6'd39, 1'b0, 1'b0}, '{"SITE", 6'd40, 1'b1, 1'b1},
        '{"P@SW", 6'd41, 1'b0, 1'b0}, '{"STRU", 6'd42, 1'b1, 1'b0},
        '{"CLNT", 6'd43, 1'b1, 1'b1}, '{"MFMT", 6'd44, 1'b1, 1'b0},
        '{"HASH", 6'd45, 1'b1, 1'b0}, '{"REIN", 6'd46, 1'b0, 1'b0},
        '{"STAT", 6'd47, 1'b0, 1'b0}
    };

    typedef struct {
        logic       kind;
        logic [7:0] arg;
        logic [5:0] cmd;
        logic [2:0] status;
        logic [9:0] reply;
    } t_parse_out;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_logged_on = 1'b0;
    logic       i_rx_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'd0;
    logic       i_res_ready = 1'b1;
    logic       o_rx_ready;
    logic       o_res_valid;
    logic       o_kind;
    logic [7:0] o_arg_byte;
    logic [5:0] o_command_id;
    logic [2:0] o_status;
    logic [9:0] o_reply_code;

    // line state of the predictor
    logic        session_on = 1'b0;
    logic        in_telnet = 1'b0;
    logic [10:0] line_len = '0;
    logic        space_seen = 1'b0;
    logic [31:0] kw_word = '0;
    logic [2:0]  kw_len = '0;
    logic        arg_seen = 1'b0;

    t_parse_out pending_q[$];
    bit         steady = 1'b0;
    int         n_fail = 0;
    int         n_bytes = 0;
    int         n_args = 0;
    int         n_verdicts = 0;
    int         quiet_cycles = 0;

    ftp_command_line_parser #(.MAX_LINE(LINE_LIMIT)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_logged_on (i_cfg_logged_on),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_kind          (o_kind),
        .o_arg_byte      (o_arg_byte),
        .o_command_id    (o_command_id),
        .o_status        (o_status),
        .o_reply_code    (o_reply_code)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_expected(input t_parse_out r);
        pending_q.insert(pending_q.size(), r);
    endfunction

    function automatic t_parse_out line_verdict();
        t_parse_out r;
        r = '{fcp_pkg::KIND_VERDICT, 8'd0, fcp_pkg::ID_NONE, fcp_pkg::ST_UNREC,
              fcp_pkg::RC_UNREC};
        if (kw_len == 0) begin
            r.status = fcp_pkg::ST_EMPTY;
            r.reply  = fcp_pkg::RC_NONE;
        end else if (kw_len <= fcp_pkg::KLEN_WORD) begin
            foreach (COMMANDS[i]) begin
                if (COMMANDS[i].word == kw_word) begin
                    // argument check wins over the logon check
                    if (COMMANDS[i].arg_req && !arg_seen) begin
                        r.status = fcp_pkg::ST_NOARG;
                        r.reply  = fcp_pkg::RC_NOARG;
                    end else if (!session_on && !COMMANDS[i].open_cmd) begin
                        r.status = fcp_pkg::ST_LOGIN;
                        r.reply  = fcp_pkg::RC_LOGIN;
                    end else begin
                        r.cmd    = COMMANDS[i].id;
                        r.status = fcp_pkg::ST_OK;
                        r.reply  = fcp_pkg::RC_NONE;
                    end
                    return r;
                end
            end
        end
        return r;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        logic [7:0] up;
        if (line_len == 0) begin
            if (in_telnet) begin
                if (b < fcp_pkg::TN_CMD_LO)
                    in_telnet = 1'b0;
                else
                    return;
            end else if (b == fcp_pkg::TN_IAC) begin
                in_telnet = 1'b1;
                return;
            end
        end
        if (b == fcp_pkg::CH_CR || b == fcp_pkg::CH_LF || b == fcp_pkg::CH_NUL) begin
            if (line_len != 0) begin
                add_expected(line_verdict());
                line_len   = '0;
                space_seen = 1'b0;
                kw_word    = '0;
                kw_len     = '0;
                arg_seen   = 1'b0;
            end
            return;
        end
        // bytes past the line limit are dropped silently
        if (line_len >= LINE_LIMIT)
            return;
        line_len++;
        if (space_seen) begin
            arg_seen = 1'b1;
            add_expected(t_parse_out'{fcp_pkg::KIND_ARG, b, fcp_pkg::ID_NONE,
                                      fcp_pkg::ST_OK, fcp_pkg::RC_NONE});
            return;
        end
        if (b == fcp_pkg::CH_SPACE) begin
            space_seen = 1'b1;
            return;
        end
        if (kw_len < fcp_pkg::KLEN_WORD) begin
            up = (b >= fcp_pkg::CH_LOW_A && b <= fcp_pkg::CH_LOW_Z) ?
                 b - fcp_pkg::CH_CASE : b;
            kw_word = {kw_word[23:0], up};
            kw_len++;
        end else begin
            kw_len = fcp_pkg::KLEN_LONG;
        end
    endfunction

    // one beat on the rx channel; valid stays high afterwards for back-to-back beats
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 9) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        parse_byte(b);
        n_bytes++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
            c = 8'($urandom_range(1, 255));
        else
            c = 8'($urandom_range(33, 126));
        if (c == fcp_pkg::CH_LF || c == fcp_pkg::CH_CR)
            c = "x";
        return c;
    endfunction

    task automatic send_line_end();
        case ($urandom_range(0, 3))
            0: send_byte(fcp_pkg::CH_CR);
            1: send_byte(fcp_pkg::CH_LF);
            2: send_byte(fcp_pkg::CH_NUL);
            default: begin
                // second byte of the pair lands on an empty line
                send_byte(fcp_pkg::CH_CR);
                send_byte(fcp_pkg::CH_LF);
            end
        endcase
    endtask

    // wait until the block has nothing left in flight
    task automatic settle();
        i_rx_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_logged_on(input logic v);
        settle();
        i_cfg_we        <= 1'b1;
        i_cfg_logged_on <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        session_on = v;
    endtask

    task automatic test_before_logon();
        write_logged_on(1'b0);
        send_text("USER bob\r");
        send_text("user\n");
        send_text("XCWD\r");
        send_text("cwd /\n");
        send_text("P@SW\r");
        send_text("Feat \r");
        send_text(" abc\r");
        send_text("FOOBAR x");
        send_byte(fcp_pkg::CH_NUL);
        send_byte(fcp_pkg::CH_NUL);
    endtask

    task automatic test_telnet();
        send_byte(fcp_pkg::TN_IAC);
        send_byte(8'd244);
        send_text("QUIT\r");
        send_byte(fcp_pkg::TN_IAC);
        send_byte(fcp_pkg::TN_IAC);
        send_byte(fcp_pkg::TN_CMD_LO);
        send_text("help\r");
        send_byte(fcp_pkg::TN_IAC);
        send_byte(fcp_pkg::CH_CR);
        send_text("SITE ");
        send_byte(fcp_pkg::TN_IAC);
        send_byte(8'h80);
        send_byte(fcp_pkg::CH_LF);
    endtask

    task automatic test_after_logon();
        write_logged_on(1'b1);
        send_text("CWD /tmp\r");
        send_text("xpwd\n");
        send_text("nop\r");
        send_text("stat\r");
        send_text("RETR \r");
        send_text("RETRY f\r");
        send_text("P`SW\r");
    endtask

    task automatic test_long_line();
        int i;
        send_text("PASS ");
        for (i = 0; i < LONG_ARG; i++)
            send_byte(rand_text_byte());
        // mid-line 255 is plain argument data
        send_byte(fcp_pkg::TN_IAC);
        send_byte(fcp_pkg::CH_CR);
    endtask

    task automatic send_command_line(input int idx);
        logic [31:0] w;
        logic [7:0]  c;
        int          i;
        int          n;
        w = COMMANDS[idx].word;
        if ($urandom_range(0, 9) == 0) begin
            send_byte(fcp_pkg::TN_IAC);
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(240, 255)));
        end
        for (i = (w[31:24] == 8'd0) ? 2 : 3; i >= 0; i--) begin
            c = w[8*i +: 8];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1))
                c = c | fcp_pkg::CH_CASE;
            send_byte(c);
        end
        if ($urandom_range(0, 9) == 0)
            send_byte(8'($urandom_range(33, 126)));
        n = $urandom_range(0, 9);
        if (n >= 3) begin
            send_byte(fcp_pkg::CH_SPACE);
            repeat (n - 3) send_byte(rand_text_byte());
        end
        send_line_end();
    endtask

    task automatic test_random();
        int phase;
        int goal;
        int idx;
        int r;
        idx = $urandom_range(0, N_CMDS - 1);
        for (phase = 0; phase < 6; phase++) begin
            write_logged_on(phase[0] ^ 1'b1);
            steady = (phase == 2);
            goal = n_bytes + 170;
            while (n_bytes < goal) begin
                r = $urandom_range(0, 99);
                if (r < 72) begin
                    send_command_line(idx);
                    idx = (idx + 1) % N_CMDS;
                end else if (r < 80) begin
                    send_byte(fcp_pkg::CH_SPACE);
                    repeat ($urandom_range(0, 6)) send_byte(rand_text_byte());
                    send_line_end();
                end else begin
                    // raw noise, may leave a line open across the next beats
                    repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        steady = 1'b0;
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_parse_out want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d byte %0d id %0d",
                         $time, o_kind, o_arg_byte, o_command_id);
                n_fail++;
            end else begin
                want = pending_q[0];
                pending_q.delete(0);
                check_field("kind", want.kind, o_kind);
                check_field("arg_byte", want.arg, o_arg_byte);
                check_field("command_id", want.cmd, o_command_id);
                check_field("status", want.status, o_status);
                check_field("reply_code", want.reply, o_reply_code);
                if (want.kind == fcp_pkg::KIND_VERDICT)
                    n_verdicts++;
                else
                    n_args++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!steady && $urandom_range(0, 99) < 9)
            i_res_ready <= 1'b0;
        else
            i_res_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no beat for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_before_logon();
        test_telnet();
        test_after_logon();
        test_long_line();
        test_random();
        settle();
        if (pending_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_q.size());
            n_fail++;
        end
        $display("covered %0d bytes: %0d argument beats and %0d verdicts checked",
                 n_bytes, n_args, n_verdicts);
        $display("both logon settings, telnet skips, a long argument line, all command words, noise");
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
